/* hdl/pss_pkg.sv */
// Package for the path string-pull smoother: payload structs, mode codes,
// the token that walks the segment cell row, and the orientation helpers.
// No dependencies.
package pss_pkg;

	// Coordinate format: signed Q12.12.
	localparam int CoordBits = 24;
	// A coordinate difference needs one more bit, a product twice that.
	localparam int DiffBits  = CoordBits + 1;
	localparam int ProdBits  = 2 * DiffBits;

	typedef logic signed [CoordBits-1:0] coord_t;
	typedef logic signed [DiffBits-1:0]  diff_t;
	typedef logic signed [ProdBits-1:0]  prod_t;

	// Transaction modes.
	localparam logic [1:0] ModeClear = 2'd0;
	localparam logic [1:0] ModeAdd   = 2'd1;
	localparam logic [1:0] ModePoint = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		coord_t     x_a;
		coord_t     y_a;
		coord_t     z_a;
		coord_t     x_b;
		coord_t     z_b;
		logic       is_last;
	} item_t;

	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
		coord_t out_z;
		logic   end_of_path;
	} result_t;

	// Query that moves one cell per cycle: anchor a, point b, running hit flag.
	typedef struct packed {
		logic   vld;
		coord_t ax;
		coord_t az;
		coord_t px;
		coord_t pz;
		logic   hit;
	} tok_t;

	// Sign of one orientation test.
	typedef struct packed {
		logic neg;
		logic nz;
	} orient_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_TEST,
		S_PREV,
		S_LAST
	} ctl_state_t;

	// Exact difference of two coordinates.
	function automatic diff_t diff(coord_t p, coord_t q);
		diff_t pe;
		diff_t qe;
		pe = DiffBits'(p);
		qe = DiffBits'(q);
		return pe - qe;
	endfunction

	// Exact signed product of two differences.
	function automatic prod_t mul(diff_t a, diff_t b);
		prod_t ae;
		prod_t be;
		ae = ProdBits'(a);
		be = ProdBits'(b);
		return ae * be;
	endfunction

	// Sign of p1 - p2, computed one bit wider so it never overflows.
	function automatic orient_t orient(prod_t p1, prod_t p2);
		logic signed [ProdBits:0] d;
		orient_t o;
		d     = (ProdBits + 1)'(p1) - (ProdBits + 1)'(p2);
		o.neg = d[ProdBits];
		o.nz  = |d;
		return o;
	endfunction

	// Both signs nonzero and opposite.
	function automatic logic opposite(orient_t o, orient_t p);
		return o.nz & p.nz & (o.neg ^ p.neg);
	endfunction

endpackage

/* hdl/path_string_pull_smoother_unit.sv */
// Path string-pull smoother. Clear and add transactions are taken while idle. A tested
// point holds the input while the query walks the cell row; each kept point holds it
// further until the output register is free of a stalled result.
// Reset clears the control state, the fill count and the slot live bits;
// stored segment coordinates keep whatever they held.
module path_string_pull_smoother_unit #(
	parameter int MAX_SEGMENTS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  pss_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output pss_pkg::result_t result
);

	localparam int CntBits = $clog2(MAX_SEGMENTS + 1);
	localparam int IdxBits = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

	pss_pkg::ctl_state_t state_q, state_d;
	logic [CntBits-1:0]  count_q;
	pss_pkg::coord_t     anc_x_q, anc_z_q;
	pss_pkg::coord_t     prv_x_q, prv_y_q, prv_z_q;
	logic                seen_q, skip_q;
	pss_pkg::coord_t     pt_x_q, pt_y_q, pt_z_q;
	logic                last_q;
	logic                out_vld_q;
	pss_pkg::result_t    out_q;

	logic accept, is_pt, do_clear, do_add;
	logic first_pt, skip_pt, launch;
	logic test_done, test_hit, test_miss;
	logic out_free, prev_emit, last_emit, out_load;

	pss_pkg::tok_t tok_launch, tok_exit;

	// Control outputs of the sequencer.
	always_comb begin
		accept    = item_valid & (state_q == pss_pkg::S_IDLE);
		is_pt     = accept & (item.mode == pss_pkg::ModePoint);
		do_clear  = accept & (item.mode == pss_pkg::ModeClear);
		do_add    = accept & (item.mode == pss_pkg::ModeAdd)
		            & (count_q < CntBits'(MAX_SEGMENTS));
		first_pt  = is_pt & ~seen_q;
		skip_pt   = is_pt & seen_q & skip_q;
		launch    = is_pt & seen_q & ~skip_q;
		test_done = (state_q == pss_pkg::S_TEST) & tok_exit.vld;
		test_hit  = test_done & tok_exit.hit;
		test_miss = test_done & ~tok_exit.hit;
		out_free  = ~out_vld_q | ~result_stall;
		prev_emit = (state_q == pss_pkg::S_PREV) & out_free;
		last_emit = (state_q == pss_pkg::S_LAST) & out_free;
		out_load  = prev_emit | last_emit;
		item_stall = (state_q != pss_pkg::S_IDLE);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pss_pkg::S_IDLE: begin
				if (first_pt) begin
					state_d = pss_pkg::S_LAST;
				end else if (skip_pt) begin
					state_d = item.is_last ? pss_pkg::S_LAST : pss_pkg::S_IDLE;
				end else if (launch) begin
					state_d = pss_pkg::S_TEST;
				end
			end
			pss_pkg::S_TEST: begin
				if (test_hit) begin
					state_d = pss_pkg::S_PREV;
				end else if (test_miss) begin
					state_d = last_q ? pss_pkg::S_LAST : pss_pkg::S_IDLE;
				end
			end
			pss_pkg::S_PREV: begin
				if (out_free) begin
					state_d = last_q ? pss_pkg::S_LAST : pss_pkg::S_IDLE;
				end
			end
			pss_pkg::S_LAST: begin
				if (out_free) begin
					state_d = pss_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pss_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pss_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Segment fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_clear) begin
			count_q <= '0;
		end else if (do_add) begin
			count_q <= count_q + CntBits'(1);
		end
	end

	// Path state: seen and skip flags, anchor and previous point.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= 1'b0;
			skip_q  <= 1'b0;
			anc_x_q <= '0;
			anc_z_q <= '0;
			prv_x_q <= '0;
			prv_y_q <= '0;
			prv_z_q <= '0;
		end else begin
			if (first_pt && !item.is_last) begin
				seen_q  <= 1'b1;
				skip_q  <= 1'b1;
				anc_x_q <= item.x_a;
				anc_z_q <= item.z_a;
				prv_x_q <= item.x_a;
				prv_y_q <= item.y_a;
				prv_z_q <= item.z_a;
			end
			if (skip_pt) begin
				skip_q  <= 1'b0;
				prv_x_q <= item.x_a;
				prv_y_q <= item.y_a;
				prv_z_q <= item.z_a;
				if (item.is_last) begin
					seen_q <= 1'b0;
				end
			end
			if (prev_emit) begin
				anc_x_q <= prv_x_q;
				anc_z_q <= prv_z_q;
			end
			if (test_miss || prev_emit) begin
				prv_x_q <= pt_x_q;
				prv_y_q <= pt_y_q;
				prv_z_q <= pt_z_q;
				if (last_q) begin
					seen_q <= 1'b0;
				end
			end
		end
	end

	// The point in work.
	always_ff @(posedge clk) begin
		if (is_pt) begin
			pt_x_q <= item.x_a;
			pt_y_q <= item.y_a;
			pt_z_q <= item.z_a;
			last_q <= item.is_last;
		end
	end

	// Query from the anchor to the new point enters the cell row.
	always_comb begin
		tok_launch.vld = launch;
		tok_launch.ax  = anc_x_q;
		tok_launch.az  = anc_z_q;
		tok_launch.px  = item.x_a;
		tok_launch.pz  = item.z_a;
		tok_launch.hit = 1'b0;
	end

	pss_chain #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.IDX_BITS     (IdxBits)
	) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.tok_in  (tok_launch),
		.clr     (do_clear),
		.wr      (do_add),
		.wr_idx  (count_q[IdxBits-1:0]),
		.seg_sx  (item.x_a),
		.seg_sz  (item.z_a),
		.seg_ex  (item.x_b),
		.seg_ez  (item.z_b),
		.tok_out (tok_exit)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (!result_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (prev_emit) begin
			out_q.out_x       <= prv_x_q;
			out_q.out_y       <= prv_y_q;
			out_q.out_z       <= prv_z_q;
			out_q.end_of_path <= 1'b0;
		end else if (last_emit) begin
			out_q.out_x       <= pt_x_q;
			out_q.out_y       <= pt_y_q;
			out_q.out_z       <= pt_z_q;
			out_q.end_of_path <= last_q;
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

`ifndef SYNTHESIS
	// The query leaves the cell row only while the sequencer waits for it.
	a_exit_in_test: assert property (@(posedge clk) disable iff (!arst_n)
		tok_exit.vld |-> (state_q == pss_pkg::S_TEST))
		else $error("query left the cell row outside the test state");

	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_vld_q || !result_stall))
		else $error("output register loaded while a result was stalled");

	// The fill count never passes the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntBits'(MAX_SEGMENTS))
		else $error("segment count beyond table size");

	// A query is launched only while no other one is in the row.
	a_one_query: assert property (@(posedge clk) disable iff (!arst_n)
		launch |=> (state_q == pss_pkg::S_TEST))
		else $error("launched query not tracked by the sequencer");
`endif

endmodule

/* hdl/pss_cell.sv */
// One segment cell: holds a border segment, tests the passing query segment
// against it and hands the query to the next cell. Depends on pss_pkg.
module pss_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  pss_pkg::tok_t   tok_in,
	input  logic            clr,
	input  logic            wr,
	input  pss_pkg::coord_t seg_sx,
	input  pss_pkg::coord_t seg_sz,
	input  pss_pkg::coord_t seg_ex,
	input  pss_pkg::coord_t seg_ez,
	output pss_pkg::tok_t   tok_out
);

	logic            active_q;
	pss_pkg::coord_t sx_q, sz_q, ex_q, ez_q;
	pss_pkg::tok_t   tok_q;
	pss_pkg::prod_t  p_q [8];

	pss_pkg::diff_t  ca_x, ca_z, da_x, da_z, cb_x, cb_z, db_x, db_z, ba_x, ba_z;
	pss_pkg::orient_t o0, o1, o2, o3;
	logic            seg_hit;

	// The segment slot is live between its write and the next clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (clr) begin
			active_q <= 1'b0;
		end else if (wr) begin
			active_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			sx_q <= seg_sx;
			sz_q <= seg_sz;
			ex_q <= seg_ex;
			ez_q <= seg_ez;
		end
	end

	// Differences against the incoming query: a is the anchor, b the point,
	// c and d the stored segment ends.
	always_comb begin
		ca_x = pss_pkg::diff(sx_q, tok_in.ax);
		ca_z = pss_pkg::diff(sz_q, tok_in.az);
		da_x = pss_pkg::diff(ex_q, tok_in.ax);
		da_z = pss_pkg::diff(ez_q, tok_in.az);
		cb_x = pss_pkg::diff(sx_q, tok_in.px);
		cb_z = pss_pkg::diff(sz_q, tok_in.pz);
		db_x = pss_pkg::diff(ex_q, tok_in.px);
		db_z = pss_pkg::diff(ez_q, tok_in.pz);
		ba_x = pss_pkg::diff(tok_in.px, tok_in.ax);
		ba_z = pss_pkg::diff(tok_in.pz, tok_in.az);
	end

	// Cross products, registered before the sign compare. Each orientation is
	// the sign of u_z * v_x - u_x * v_z.
	always_ff @(posedge clk) begin
		p_q[0] <= pss_pkg::mul(ca_z, da_x);
		p_q[1] <= pss_pkg::mul(ca_x, da_z);
		p_q[2] <= pss_pkg::mul(cb_z, db_x);
		p_q[3] <= pss_pkg::mul(cb_x, db_z);
		p_q[4] <= pss_pkg::mul(ba_z, ca_x);
		p_q[5] <= pss_pkg::mul(ba_x, ca_z);
		p_q[6] <= pss_pkg::mul(ba_z, da_x);
		p_q[7] <= pss_pkg::mul(ba_x, da_z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_in;
		end
	end

	// A proper crossing needs strictly opposite signs on both pairs.
	always_comb begin
		o0      = pss_pkg::orient(p_q[0], p_q[1]);
		o1      = pss_pkg::orient(p_q[2], p_q[3]);
		o2      = pss_pkg::orient(p_q[4], p_q[5]);
		o3      = pss_pkg::orient(p_q[6], p_q[7]);
		seg_hit = active_q & pss_pkg::opposite(o0, o1) & pss_pkg::opposite(o2, o3);
	end

	always_comb begin
		tok_out     = tok_q;
		tok_out.hit = tok_q.hit | (tok_q.vld & seg_hit);
	end

endmodule

/* hdl/pss_chain.sv */
// Row of segment cells: decodes the table write to one slot and passes the
// query token from cell to cell. Depends on pss_pkg and pss_cell.
module pss_chain #(
	parameter int MAX_SEGMENTS = 64,
	parameter int IDX_BITS     = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pss_pkg::tok_t       tok_in,
	input  logic                clr,
	input  logic                wr,
	input  logic [IDX_BITS-1:0] wr_idx,
	input  pss_pkg::coord_t     seg_sx,
	input  pss_pkg::coord_t     seg_sz,
	input  pss_pkg::coord_t     seg_ex,
	input  pss_pkg::coord_t     seg_ez,
	output pss_pkg::tok_t       tok_out
);

	pss_pkg::tok_t tok [MAX_SEGMENTS+1];

	assign tok[0]  = tok_in;
	assign tok_out = tok[MAX_SEGMENTS];

	for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
		logic wr_here;

		// Only the slot named by the fill count takes the new segment.
		assign wr_here = wr & (wr_idx == IDX_BITS'(i));

		pss_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[i]),
			.clr     (clr),
			.wr      (wr_here),
			.seg_sx  (seg_sx),
			.seg_sz  (seg_sz),
			.seg_ex  (seg_ex),
			.seg_ez  (seg_ez),
			.tok_out (tok[i+1])
		);
	end

endmodule
